// ===== hdl/cc_pkg.sv =====
// ----------------------------------------------------------------------------
// cc_pkg
// Shared types, codes and preset tables for the chess clock.
// ----------------------------------------------------------------------------
package cc_pkg;

  // Request codes on the input tuser.
  localparam logic [1:0] REQ_PRESS = 2'd0;
  localparam logic [1:0] REQ_MOVE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [2:0] PRESET_LAST = 3'd6;

  // Reciprocal of 60 scaled by 2^21, exact for values below 2^15.
  localparam logic [15:0] RECIP60       = 16'd34953;
  localparam int          RECIP60_SHIFT = 21;

  typedef enum logic [1:0] {
    MODE_WAITING  = 2'd0,
    MODE_ONGOING  = 2'd1,
    MODE_FINISHED = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    DISP_MENU  = 2'd0,
    DISP_START = 2'd1,
    DISP_TIME  = 2'd2,
    DISP_OVER  = 2'd3
  } disp_t;

  // Classified operation handed from front to back.
  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_SHORT = 3'd1,
    OP_LONG  = 3'd2,
    OP_MOVE  = 3'd3,
    OP_TICK  = 3'd4
  } op_t;

  // Clock state after one operation.
  typedef struct packed {
    mode_t              mode;
    logic               side;
    logic [2:0]         preset;
    logic               opening;
    logic signed [15:0] white;
    logic signed [15:0] black;
  } snap_t;

  typedef struct packed {
    mode_t              run_state;
    logic               to_move;
    logic [2:0]         preset;
    disp_t              display_kind;
    logic [9:0]         minutes;
    logic [5:0]         seconds;
    logic signed [15:0] white_seconds;
    logic signed [15:0] black_seconds;
  } res_t;

  function automatic logic [10:0] preset_start(input logic [2:0] idx);
    logic [10:0] r;
    case (idx)
      3'd0:    r = 11'd180;
      3'd1:    r = 11'd180;
      3'd2:    r = 11'd300;
      3'd3:    r = 11'd600;
      3'd4:    r = 11'd900;
      3'd5:    r = 11'd1800;
      default: r = 11'd180;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] preset_inc(input logic [2:0] idx);
    logic [3:0] r;
    case (idx)
      3'd1:    r = 4'd2;
      3'd4:    r = 4'd10;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/cc_front.sv =====
// ----------------------------------------------------------------------------
// cc_front
// Input side: holds the long-press threshold and classifies each request.
// ----------------------------------------------------------------------------
module cc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,
  input  logic             in_valid,
  input  logic [1:0]       req_type,
  input  logic [7:0]       press_duration,
  output logic             push,
  output cc_pkg::op_t      push_op,
  input  logic             q_ready
);
  import cc_pkg::*;

  logic [7:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 8'd3;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  always_comb begin
    unique case (req_type)
      REQ_PRESS: push_op = (press_duration > threshold) ? OP_LONG : OP_SHORT;
      REQ_MOVE:  push_op = OP_MOVE;
      REQ_TICK:  push_op = OP_TICK;
      default:   push_op = OP_NOP;
    endcase
  end

  assign push = in_valid && q_ready;

endmodule

// ===== hdl/cc_queue.sv =====
// ----------------------------------------------------------------------------
// cc_queue
// Two-entry operation queue between front and back.
// ----------------------------------------------------------------------------
module cc_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  cc_pkg::op_t push_op,
  output logic        ready,
  output logic        valid,
  output cc_pkg::op_t pop_op,
  input  logic        pop
);
  import cc_pkg::*;

  op_t        mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign ready  = (count != 2'd2);
  assign valid  = (count != 2'd0);
  assign pop_op = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/cc_back.sv =====
// ----------------------------------------------------------------------------
// cc_back
// Clock state and event execution; one operation per cycle while snap_ready is high.
// ----------------------------------------------------------------------------
module cc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  input  cc_pkg::op_t   op,
  output logic          pop,
  input  logic          snap_ready,
  output logic          snap_valid,
  output cc_pkg::snap_t snap
);
  import cc_pkg::*;

  mode_t              mode, mode_next;
  logic [2:0]         preset, preset_next;
  logic [10:0]        start_sec, start_sec_next;
  logic [3:0]         inc_sec, inc_sec_next;
  logic               side, side_next;
  logic               opening, opening_next;
  logic signed [15:0] white, white_next;
  logic signed [15:0] black, black_next;
  logic [2:0]         preset_adv;

  // Add increment, saturate at the top of the range.
  function automatic logic signed [15:0] credit(input logic signed [15:0] t,
                                                input logic [3:0] inc);
    logic signed [16:0] s;
    s = {t[15], t} + $signed({13'd0, inc});
    return (s > 17'sd32767) ? 16'sd32767 : s[15:0];
  endfunction

  function automatic logic signed [15:0] charge(input logic signed [15:0] t);
    return (t == -16'sd32768) ? t : t - 16'sd1;
  endfunction

  assign pop        = op_valid && snap_ready;
  assign snap_valid = op_valid;
  assign preset_adv = (preset < PRESET_LAST) ? preset + 3'd1 : 3'd0;

  always_comb begin
    mode_next      = mode;
    preset_next    = preset;
    start_sec_next = start_sec;
    inc_sec_next   = inc_sec;
    side_next      = side;
    opening_next   = opening;
    white_next     = white;
    black_next     = black;
    unique case (op)
      OP_SHORT: begin
        preset_next = preset_adv;
        if (preset_adv < PRESET_LAST) begin
          start_sec_next = preset_start(preset_adv);
          inc_sec_next   = preset_inc(preset_adv);
        end
        mode_next = MODE_WAITING;
      end
      OP_LONG: begin
        if (mode == MODE_FINISHED) begin
          mode_next      = MODE_WAITING;
          preset_next    = 3'd0;
          start_sec_next = preset_start(3'd0);
          inc_sec_next   = preset_inc(3'd0);
        end else begin
          side_next    = 1'b0;
          white_next   = $signed({5'd0, start_sec});
          black_next   = $signed({5'd0, start_sec});
          mode_next    = MODE_ONGOING;
          opening_next = 1'b1;
        end
      end
      OP_MOVE: begin
        if (mode == MODE_ONGOING) begin
          if (!side) white_next = credit(white, inc_sec);
          else       black_next = credit(black, inc_sec);
          side_next = ~side;
        end
      end
      OP_TICK: begin
        if (mode == MODE_ONGOING) begin
          if (!side) begin
            if (opening) opening_next = 1'b0;
            else         white_next   = charge(white);
          end else begin
            black_next = charge(black);
          end
          if (white_next[15] || black_next[15]) mode_next = MODE_FINISHED;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    snap.mode    = mode_next;
    snap.side    = side_next;
    snap.preset  = preset_next;
    snap.opening = opening_next;
    snap.white   = white_next;
    snap.black   = black_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_WAITING;
      preset    <= 3'd0;
      start_sec <= 11'd180;
      inc_sec   <= 4'd0;
      side      <= 1'b0;
      opening   <= 1'b0;
      white     <= 16'sd0;
      black     <= 16'sd0;
    end else if (pop) begin
      mode      <= mode_next;
      preset    <= preset_next;
      start_sec <= start_sec_next;
      inc_sec   <= inc_sec_next;
      side      <= side_next;
      opening   <= opening_next;
      white     <= white_next;
      black     <= black_next;
    end
  end

endmodule

// ===== hdl/cc_fmt.sv =====
// ----------------------------------------------------------------------------
// cc_fmt
// Result pipeline: display kind, minutes/seconds split, output register.
// ----------------------------------------------------------------------------
module cc_fmt (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  cc_pkg::snap_t in_snap,
  output logic          in_ready,
  output logic          out_valid,
  output cc_pkg::res_t  out_res,
  input  logic          out_ready
);
  import cc_pkg::*;

  logic               v1, v2, v3;
  logic               en1, en2, en3;
  snap_t              s1;
  snap_t              s2;
  disp_t              disp2;
  logic               show2;
  logic [14:0]        act2;
  logic [30:0]        prod2;
  logic signed [15:0] act_c;
  disp_t              disp_c;
  logic [9:0]         mins_c;
  logic [15:0]        m60_c;
  logic [15:0]        rem_c;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v3;

  assign act_c = s1.side ? s1.black : s1.white;

  always_comb begin
    unique case (s1.mode)
      MODE_WAITING:  disp_c = DISP_MENU;
      MODE_FINISHED: disp_c = DISP_OVER;
      MODE_ONGOING:  disp_c = (!s1.side && s1.opening) ? DISP_START : DISP_TIME;
      default:       disp_c = DISP_MENU;
    endcase
  end

  // divide by 60: quotient from the scaled reciprocal, remainder by subtract
  assign mins_c = prod2[30:RECIP60_SHIFT];
  assign m60_c  = {mins_c, 6'd0} - {4'd0, mins_c, 2'd0};
  assign rem_c  = {1'b0, act2} - m60_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1 <= in_snap;
    end
    if (en2) begin
      s2    <= s1;
      disp2 <= disp_c;
      show2 <= (s1.mode != MODE_FINISHED) && !act_c[15];
      act2  <= act_c[14:0];
      prod2 <= 31'(act_c[14:0]) * 31'(RECIP60);
    end
    if (en3) begin
      out_res.run_state     <= s2.mode;
      out_res.to_move       <= s2.side;
      out_res.preset        <= s2.preset;
      out_res.display_kind  <= disp2;
      out_res.minutes       <= show2 ? mins_c : 10'd0;
      out_res.seconds       <= show2 ? rem_c[5:0] : 6'd0;
      out_res.white_seconds <= s2.white;
      out_res.black_seconds <= s2.black;
    end
  end

endmodule

// ===== hdl/chess_clock_with_increment.sv =====
// ----------------------------------------------------------------------------
// chess_clock_with_increment
// Two-player countdown clock with per-move increment and preset menu.
// ----------------------------------------------------------------------------
// Path: a result follows its request transfer through the queue, state
//   update, divide-by-60 multiply and output register.
// Throughput: one request per cycle while the result stream is not stalled;
//   the single state-update step in the back end bounds it.
// Reset: rst (sync, high) empties queue and pipeline, sets threshold to 3,
//   menu mode, preset 0 (180 s, no increment), both times zero.
module chess_clock_with_increment (
  input  logic        clk,
  input  logic        rst,
  // configuration: long-press threshold
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] press_duration
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [1:0] run state, [2] side to move,
                                      // [5:3] preset, [15:6] minutes,
                                      // [21:16] seconds, [37:22] white_seconds,
                                      // [53:38] black_seconds, [55:54] zero
  output logic [1:0]  m_axis_tuser    // [1:0] display_kind
);
  import cc_pkg::*;

  logic  push;
  op_t   push_op;
  logic  q_ready;
  logic  q_valid;
  op_t   q_op;
  logic  pop;
  logic  snap_ready;
  logic  snap_valid;
  snap_t snap;
  res_t  res;

  // Front: classify press as short/long against the threshold.
  cc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (s_axis_tvalid),
    .req_type       (s_axis_tuser),
    .press_duration (s_axis_tdata),
    .push           (push),
    .push_op        (push_op),
    .q_ready        (q_ready)
  );

  assign s_axis_tready = q_ready;

  // Decouples request acceptance from result back-pressure.
  cc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .ready   (q_ready),
    .valid   (q_valid),
    .pop_op  (q_op),
    .pop     (pop)
  );

  // Back: game state machine, times, presets.
  cc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (q_valid),
    .op         (q_op),
    .pop        (pop),
    .snap_ready (snap_ready),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  // Result formatting and output register.
  cc_fmt u_fmt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (snap_valid),
    .in_snap   (snap),
    .in_ready  (snap_ready),
    .out_valid (m_axis_tvalid),
    .out_res   (res),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, res.black_seconds, res.white_seconds, res.seconds,
                         res.minutes, res.preset, res.to_move, res.run_state};
  assign m_axis_tuser = res.display_kind;

endmodule

// ===== hdl/cc_checker.sv =====
// ----------------------------------------------------------------------------
// cc_checker
// Port-level checks for the chess clock, bound to the top level.
// ----------------------------------------------------------------------------
module cc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import cc_pkg::*;

  // held result must stay offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_over_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[1:0] == MODE_FINISHED) == (m_axis_tuser == DISP_OVER)))
    else $error("display kind disagrees with finished state");

  a_over_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[1:0] == MODE_FINISHED)
      |-> (m_axis_tdata[21:6] == 16'd0))
    else $error("time shown after game over");

  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[21:16] < 6'd60))
    else $error("seconds out of range");

endmodule

bind chess_clock_with_increment cc_checker u_cc_checker (.*);
